FILE: sv/gwm_pkg.sv
// gwm_pkg: shared types and constants for the glob wildcard matcher
// depends on nothing; used by gwm_cell, gwm_skid and glob_wildcard_matcher
package gwm_pkg;

    // command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // kind of one stored pattern element
    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_ANY  = 2'd1,
        KIND_STAR = 2'd2
    } kind_t;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_ESC  = 8'h5C;

    // per-cell control from the top level
    typedef struct packed {
        logic restart;  // reload the start position with its star closure
        logic step;     // advance on a text byte
        logic we;       // write this cell's element
        logic in_use;   // cell holds an element (after this word)
    } cell_ctl_t;

    // one result word
    typedef struct packed {
        logic overflow;
        logic final_res;
        logic alive;
        logic matched;
    } res_t;

endpackage

FILE: sv/gwm_cell.sv
// gwm_cell: one pattern element with its active position bit
// depends on gwm_pkg; chained by glob_wildcard_matcher
module gwm_cell
    import gwm_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  kind_t     wr_kind,
    input  logic [7:0] symbol,
    input  logic      carry_in,
    output logic      carry_out,
    output logic      act
);

    logic [7:0] byte_reg;
    kind_t      kind_reg;
    logic       act_reg;
    logic       act_next;
    kind_t      kind_eff;
    logic       star;
    logic       hit;
    logic       keep;
    logic       seed;

    // a fresh element takes part in the restart closure at once
    assign kind_eff = ctl.we ? wr_kind : kind_reg;
    assign star     = ctl.in_use && (kind_eff == KIND_STAR);
    assign hit      = ctl.step && act_reg && ctl.in_use &&
                      ((kind_reg == KIND_ANY) ||
                       ((kind_reg == KIND_LIT) && (byte_reg == symbol)));
    assign keep     = ctl.step && act_reg && star;
    assign seed     = ctl.restart && FIRST;
    assign act_next = seed || keep || carry_in;
    // star passes its position on without consuming a byte
    assign carry_out = (act_next && star) || hit;
    assign act       = act_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            byte_reg <= symbol;
            kind_reg <= wr_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= FIRST;
        end
        else if (ctl.restart || ctl.step)
        begin
            act_reg <= act_next;
        end
    end

endmodule

FILE: sv/gwm_skid.sv
// gwm_skid: output register with a skid stage for result words
// depends on gwm_pkg; used by glob_wildcard_matcher
module gwm_skid
    import gwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic pop;
    logic push;
    logic load_out;
    logic load_skid;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;
    assign push      = in_valid && !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= in_data;
        end
        else if (skid_valid_reg && pop)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: sv/glob_wildcard_matcher.sv
// glob_wildcard_matcher: top level, streams text against a stored glob pattern
// depends on gwm_pkg, gwm_cell (chain of element cells) and gwm_skid (output stage)
//
//  channel | dir | tdata               | tuser      | meaning
//  s_*     | in  | [7:0] symbol        | [1:0] cmd  | clear, append, text byte, end
//  m_*     | out | [0] matched         | [0] final  | one result word per input word
//          |     | [1] alive           |            |
//          |     | [2] overflow        |            |
//
// a text byte advances all active positions of the cell chain, stars pass positions on
// through the ripple along the chain; the result word is registered at the accepting
// edge (in the skid stage if the output register holds a word not taken) and offered
// on m_* from the output register; s_tready drops only while both registers hold a
// word, so under a stall on m_* at most two words are taken before input stops
// reset leaves an empty pattern with the start position active
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [1] alive, [2] overflow, [7:3] zero
    output logic       m_tuser    // [0] final_res
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  esc_reg;
    logic                  esc_next;
    logic                  last_reg;     // position past the final element
    logic                  accept;
    cmd_t                  cmd;
    logic                  full;
    logic                  do_write;
    logic                  do_restart;
    logic                  do_step;
    kind_t                 wr_kind;
    logic [MAX_ELEMENTS:0] carry;
    logic [MAX_ELEMENTS:0] act_cur;
    logic [MAX_ELEMENTS:0] act_new;
    logic [MAX_ELEMENTS:0] act_rep;
    logic                  ovf;
    res_t                  res;
    res_t                  res_out;

    assign accept = s_tvalid && s_tready;
    assign cmd    = cmd_t'(s_tuser);
    assign full   = (count_reg == CW'(MAX_ELEMENTS));

    // pattern loading, escape tracking and decoding of the text and end commands
    always_comb
    begin
        count_next = count_reg;
        esc_next   = esc_reg;
        do_write   = 1'b0;
        do_restart = 1'b0;
        do_step    = 1'b0;
        ovf        = 1'b0;
        wr_kind    = KIND_LIT;
        if (accept)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    count_next = '0;
                    esc_next   = 1'b0;
                    do_restart = 1'b1;
                end
                CMD_APPEND:
                begin
                    if (full)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        do_restart = 1'b1;
                        if (esc_reg)
                        begin
                            do_write   = 1'b1;
                            esc_next   = 1'b0;
                            count_next = count_reg + CW'(1);
                        end
                        else if (s_tdata == CH_ESC)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            do_write   = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (s_tdata == CH_STAR)
                            begin
                                wr_kind = KIND_STAR;
                            end
                            else if (s_tdata == CH_ANY)
                            begin
                                wr_kind = KIND_ANY;
                            end
                        end
                    end
                end
                CMD_TEXT:
                begin
                    do_step = 1'b1;
                end
                CMD_END:
                begin
                    do_restart = 1'b1;
                end
                default:
                begin
                    do_restart = 1'b0;
                end
            endcase
        end
    end

    // cell chain, one cell per pattern element
    assign carry[0] = 1'b0;

    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        cell_ctl_t ctl;

        assign ctl.restart = do_restart;
        assign ctl.step    = do_step;
        assign ctl.we      = do_write && (count_reg == CW'(i));
        assign ctl.in_use  = (CW'(i) < count_next);

        gwm_cell #(
            .FIRST (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_kind   (wr_kind),
            .symbol    (s_tdata),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .act       (act_cur[i])
        );

        assign act_new[i] = (i == 0) ? (do_restart || carry[i]) : carry[i];
    end

    assign act_cur[MAX_ELEMENTS] = last_reg;
    assign act_new[MAX_ELEMENTS] = carry[MAX_ELEMENTS];

    // end of text reports the state before its restart; positions past the
    // element count are always clear, so alive is a plain reduction
    always_comb
    begin
        if ((cmd == CMD_END) || !(do_restart || do_step))
        begin
            act_rep = act_cur;
        end
        else
        begin
            act_rep = act_new;
        end
    end

    assign res.matched   = !esc_next && act_rep[count_next];
    assign res.alive     = !esc_next && (|act_rep);
    assign res.final_res = (cmd == CMD_END);
    assign res.overflow  = ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            esc_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            esc_reg   <= esc_next;
            if (do_restart || do_step)
            begin
                last_reg <= carry[MAX_ELEMENTS];
            end
        end
    end

    gwm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {5'b0, res_out.overflow, res_out.alive, res_out.matched};
    assign m_tuser = res_out.final_res;

endmodule

FILE: sv/gwm_checker.sv
// gwm_checker: port-level assertions for glob_wildcard_matcher
// depends on nothing; attached to the top level by the bind below
module gwm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // a waiting input word stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input word changed while waiting");

    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // a full match implies a live position
    a_match_alive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("matched without alive");

    // overflow only answers an append, never an end of text
    a_ovf_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tuser)
        else $error("overflow on final word");

    // with no result pending the input side is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
